>>> rtl/rts_pkg.sv
// Shared types and constants for the task scheduler core.
`timescale 1ns / 1ps
`default_nettype none
package rts_pkg;

  localparam int OP_W    = 4;
  localparam int PRIO_W  = 4;
  localparam int OBJ_W   = 8;
  localparam int TICK_W  = 32;
  localparam int TASK_W  = 4;
  localparam int SLICE_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE        = 4'd0,
    OP_START         = 4'd1,
    OP_BLOCK_MUTEX   = 4'd2,
    OP_BLOCK_SEM     = 4'd3,
    OP_DELAY         = 4'd4,
    OP_UNBLOCK_MUTEX = 4'd5,
    OP_UNBLOCK_SEM   = 4'd6,
    OP_TICK          = 4'd7,
    OP_SWITCH        = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2
  } task_status_e;

  typedef enum logic [1:0] {
    WHY_NONE  = 2'd0,
    WHY_MUTEX = 2'd1,
    WHY_SEM   = 2'd2,
    WHY_TICK  = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    op_e               op;
    logic              unlock_en;
    logic [OBJ_W-1:0]  obj;
    logic [TICK_W-1:0] wake;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] run_prio;
    logic [TICK_W-1:0] tick_next;
  } cell_cmd_t;

  // Where a cell sits relative to the running and created slots.
  typedef struct packed {
    logic is_run;
    logic is_after;
    logic is_create;
  } cell_pos_t;

  // Search chain passed from cell to cell.
  typedef struct packed {
    logic first;
    logic hi;
    logic lo;
  } chain_t;

  typedef struct packed {
    logic [PRIO_W-1:0] eff_prio;
    logic              vote;
    logic              picked;
  } cell_stat_t;

endpackage
`default_nettype wire

>>> rtl/rts_cell.sv
// One task slot of the scheduler: slot state plus its link of the search chain.
`timescale 1ns / 1ps
`default_nettype none
module rts_cell #(
  parameter bit IS_IDLE = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               exec_i,
  input  wire rts_pkg::cell_cmd_t cmd_i,
  input  wire rts_pkg::cell_pos_t pos_i,
  input  wire logic               any_hi_i,
  input  wire rts_pkg::chain_t    chain_i,
  output rts_pkg::chain_t         chain_o,
  output rts_pkg::cell_stat_t     stat_o
);
  import rts_pkg::*;

  logic                valid_q, valid_d;
  task_status_e        status_q, status_d;
  reason_e             reason_q, reason_d;
  logic [OBJ_W-1:0]    obj_q, obj_d;
  logic [TICK_W-1:0]   wake_q, wake_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic [SLICE_W-1:0]  slices_q, slices_d;

  logic [PRIO_W-1:0]   eff_prio;
  logic [SLICE_W-1:0]  eff_sl;
  reason_e             want;
  logic                blk_match, match_first, cand, hi, lo, picked, woke, slice_end;
  task_status_e        st_tmp;

  localparam bit ORDINARY = !IS_IDLE;

  always_comb begin
    eff_prio  = valid_q ? prio_q : '0;
    eff_sl    = valid_q ? slices_q : '0;
    want      = (cmd_i.op == OP_UNBLOCK_MUTEX) ? WHY_MUTEX : WHY_SEM;
    blk_match = ORDINARY && valid_q && (status_q == TS_BLOCKED) &&
                (reason_q == want) && (obj_q == cmd_i.obj);
    unique case (cmd_i.op)
      OP_START:         match_first = ORDINARY && valid_q;
      OP_UNBLOCK_MUTEX: match_first = blk_match && cmd_i.unlock_en;
      OP_UNBLOCK_SEM:   match_first = blk_match;
      default:          match_first = 1'b0;
    endcase
    cand = ORDINARY && valid_q && (status_q == TS_READY) && !pos_i.is_run;
    hi   = cand && pos_i.is_after;
    lo   = cand && !pos_i.is_after;
    chain_o.first = chain_i.first | match_first;
    chain_o.hi    = chain_i.hi | hi;
    chain_o.lo    = chain_i.lo | lo;

    if (IS_IDLE) begin
      unique case (cmd_i.op)
        OP_START:  picked = !chain_i.first;
        OP_SWITCH: picked = !chain_i.hi && !chain_i.lo;
        default:   picked = 1'b0;
      endcase
    end else begin
      unique case (cmd_i.op)
        OP_START, OP_UNBLOCK_MUTEX, OP_UNBLOCK_SEM:
          picked = match_first && !chain_i.first;
        OP_SWITCH: picked = any_hi_i ? (hi && !chain_i.hi) : (lo && !chain_i.lo);
        default:   picked = 1'b0;
      endcase
    end

    woke = ORDINARY && valid_q && (status_q == TS_BLOCKED) &&
           (reason_q == WHY_TICK) && (wake_q <= cmd_i.tick_next);
    slice_end = pos_i.is_run && (eff_prio == PRIO_W'(eff_sl));

    unique case (cmd_i.op)
      OP_UNBLOCK_MUTEX, OP_UNBLOCK_SEM: stat_o.vote = picked && (eff_prio > cmd_i.run_prio);
      OP_TICK: stat_o.vote = (woke && (eff_prio > cmd_i.run_prio)) || slice_end;
      default: stat_o.vote = 1'b0;
    endcase
    stat_o.eff_prio = eff_prio;
    stat_o.picked   = picked;
  end

  always_comb begin
    valid_d  = valid_q;
    status_d = status_q;
    reason_d = reason_q;
    obj_d    = obj_q;
    wake_d   = wake_q;
    prio_d   = prio_q;
    slices_d = slices_q;
    st_tmp   = status_q;
    if (exec_i) begin
      unique case (cmd_i.op)
        OP_CREATE: begin
          if (pos_i.is_create) begin
            valid_d  = 1'b1;
            status_d = TS_READY;
            prio_d   = cmd_i.prio;
            slices_d = '0;
          end
        end
        OP_START: begin
          if (picked) status_d = TS_RUNNING;
          else if (pos_i.is_run && status_q == TS_RUNNING) status_d = TS_READY;
        end
        OP_BLOCK_MUTEX, OP_BLOCK_SEM, OP_DELAY: begin
          if (pos_i.is_run) begin
            status_d = TS_BLOCKED;
            unique case (cmd_i.op)
              OP_BLOCK_MUTEX: begin
                reason_d = WHY_MUTEX;
                obj_d    = cmd_i.obj;
              end
              OP_BLOCK_SEM: begin
                reason_d = WHY_SEM;
                obj_d    = cmd_i.obj;
              end
              default: begin
                reason_d = WHY_TICK;
                obj_d    = '0;
                wake_d   = cmd_i.wake;
              end
            endcase
          end
        end
        OP_UNBLOCK_MUTEX, OP_UNBLOCK_SEM: begin
          if (picked) status_d = TS_READY;
        end
        OP_TICK: begin
          if (woke) st_tmp = TS_READY;
          status_d = st_tmp;
          if (pos_i.is_run) begin
            if (slice_end) begin
              if (st_tmp == TS_RUNNING) status_d = TS_READY;
              slices_d = '0;
            end else begin
              slices_d = slices_q + SLICE_W'(1);
            end
          end
        end
        OP_SWITCH: begin
          if (picked) status_d = TS_RUNNING;
          else if (IS_IDLE) status_d = TS_READY;
          else if (pos_i.is_run && status_q == TS_RUNNING) status_d = TS_READY;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      status_q <= TS_READY;
      reason_q <= WHY_NONE;
    end else begin
      valid_q  <= valid_d;
      status_q <= status_d;
      reason_q <= reason_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obj_q    <= obj_d;
    wake_q   <= wake_d;
    prio_q   <= prio_d;
    slices_q <= slices_d;
  end

endmodule
`default_nettype wire

>>> rtl/rtos_task_scheduler_core.sv
// Top level of the task scheduler: command sequencer around a chain of slot cells.
`timescale 1ns / 1ps
`default_nettype none
// Each command passes through accept, load of running-slot data and execute; the results
// are registered from the execute cycle and shown with done_o. busy_o is high for the
// load and execute cycles, so no new command is taken then; the slot searches ripple
// down the cell chain within the execute cycle. Results cannot be stalled by the receiver.
// Reset: asynchronous, active low; all slots invalid and ready, running slot 0, tick 0.
module rtos_task_scheduler_core #(
  parameter int MAX_TASKS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [rts_pkg::OP_W-1:0]   op_i,
  input  wire logic [rts_pkg::PRIO_W-1:0] priority_req_i,
  input  wire logic [rts_pkg::OBJ_W-1:0]  object_id_i,
  input  wire logic                       mutex_unlocked_i,
  input  wire logic [rts_pkg::TICK_W-1:0] delay_ticks_i,
  output logic                            done_o,
  output logic                            switch_request_o,
  output logic [rts_pkg::TASK_W-1:0]      running_task_o,
  output logic [rts_pkg::TASK_W-1:0]      created_slot_o,
  output logic                            error_o
);
  import rts_pkg::*;

  localparam int NSLOTS = MAX_TASKS + 1;
  localparam int SLOT_W = $clog2(NSLOTS);

  state_e state_q, state_d;

  // Captured transaction fields.
  op_e               op_q;
  logic [PRIO_W-1:0] prio_q;
  logic [OBJ_W-1:0]  obj_q;
  logic              unl_q;
  logic [TICK_W-1:0] dly_q;

  logic [TICK_W-1:0] tick_q, tick_next_q, wake_q;
  logic [SLOT_W-1:0] running_q;
  logic [PRIO_W-1:0] run_prio_q;

  logic              done_q, sw_q, err_q;
  logic [TASK_W-1:0] run_out_q, created_q;

  cell_cmd_t         cmd;
  cell_pos_t         pos   [NSLOTS];
  chain_t            chain [NSLOTS+1];
  cell_stat_t        stat  [NSLOTS];
  logic [PRIO_W-1:0] eff_prio_arr [NSLOTS];
  logic [NSLOTS-1:0] picked_vec, vote_vec;

  logic              exec, err, sw;
  logic [SLOT_W-1:0] create_slot, pick_idx;

  assign exec   = (state_q == S_EXEC);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = (start_i) ? S_LOAD : S_IDLE;
      S_LOAD:  state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    err         = (op_q == OP_CREATE) && (prio_q > PRIO_W'(MAX_TASKS));
    create_slot = SLOT_W'(MAX_TASKS) - prio_q[SLOT_W-1:0];
    cmd.op        = op_q;
    cmd.unlock_en = unl_q;
    cmd.obj       = obj_q;
    cmd.wake      = wake_q;
    cmd.prio      = prio_q;
    cmd.run_prio  = run_prio_q;
    cmd.tick_next = tick_next_q;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < NSLOTS; g++) begin : g_cell
    always_comb begin
      pos[g].is_run    = (running_q == SLOT_W'(g));
      pos[g].is_after  = (SLOT_W'(g) > running_q);
      pos[g].is_create = (op_q == OP_CREATE) && !err && (create_slot == SLOT_W'(g));
    end

    // The idle slot sits at the tail; it takes the chain result but adds nothing.
    rts_cell #(
      .IS_IDLE (g == MAX_TASKS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .exec_i   (exec),
      .cmd_i    (cmd),
      .pos_i    (pos[g]),
      .any_hi_i (chain[MAX_TASKS].hi),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1]),
      .stat_o   (stat[g])
    );

    assign eff_prio_arr[g] = stat[g].eff_prio;
    assign picked_vec[g]   = stat[g].picked;
    assign vote_vec[g]     = stat[g].vote;
  end

  // Exactly one cell picks on start and switch; encode its index.
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (picked_vec[i]) pick_idx = pick_idx | SLOT_W'(i);
    end
    sw = (|vote_vec) || (op_q == OP_BLOCK_MUTEX) || (op_q == OP_BLOCK_SEM) ||
         (op_q == OP_DELAY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tick_q    <= '0;
      running_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) begin
        if (op_q == OP_TICK) tick_q <= tick_next_q;
        if (op_q == OP_START || op_q == OP_SWITCH) running_q <= pick_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q   <= op_e'(op_i);
      prio_q <= priority_req_i;
      obj_q  <= object_id_i;
      unl_q  <= mutex_unlocked_i;
      dly_q  <= delay_ticks_i;
    end
    if (state_q == S_LOAD) begin
      run_prio_q  <= eff_prio_arr[running_q];
      tick_next_q <= tick_q + TICK_W'(1);
      wake_q      <= tick_q + dly_q;
    end
    if (exec) begin
      sw_q      <= sw;
      err_q     <= err;
      run_out_q <= (op_q == OP_START || op_q == OP_SWITCH) ? TASK_W'(pick_idx)
                                                           : TASK_W'(running_q);
      created_q <= ((op_q == OP_CREATE) && !err) ? TASK_W'(create_slot) : '0;
    end
  end

  assign done_o           = done_q;
  assign switch_request_o = sw_q;
  assign running_task_o   = run_out_q;
  assign created_slot_o   = created_q;
  assign error_o          = err_q;

  // A result appears only right after an execute cycle.
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result strobe without execute cycle");

  // Start and switch always select exactly one slot.
  a_one_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (op_q == OP_START || op_q == OP_SWITCH)) |-> $onehot(picked_vec))
    else $error("slot selection not one-hot");

  // The running slot never leaves the table.
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q <= SLOT_W'(MAX_TASKS))
    else $error("running slot out of range");

  // An accepted transaction makes the core busy next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transaction accepted without going busy");

endmodule
`default_nettype wire

>>> test/rtos_task_scheduler_core_tb.sv
// Testbench for the task scheduler core: directed and random kernel events checked against a predictor.
`timescale 1ns / 1ps
module rtos_task_scheduler_core_tb;
  import rts_pkg::*;

  localparam int NTASK    = 8;
  localparam int NSLOT    = NTASK + 1;
  localparam int WD_LIMIT = 2000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    logic [OBJ_W-1:0]  obj;
    logic              unlocked;
    logic [TICK_W-1:0] dly;
  } event_t;

  typedef struct {
    logic              sw_req;
    logic [TASK_W-1:0] run;
    logic [TASK_W-1:0] created;
    logic              err;
  } sched_res_t;

  // Scheduler shadow: mirrors the task table and keeps the expected results in order.
  class sched_scoreboard;
    logic [TICK_W-1:0]  ticks;
    int unsigned        cur_slot;
    logic               valid_q  [NSLOT];
    task_status_e       status_q [NSLOT];
    reason_e            reason_q [NSLOT];
    logic [OBJ_W-1:0]   object_q [NSLOT];
    logic [TICK_W-1:0]  wake_q   [NSLOT];
    logic [PRIO_W-1:0]  prio_q   [NSLOT];
    logic [SLICE_W-1:0] slices_q [NSLOT];
    sched_res_t         expected_q[$];
    int                 mismatches;

    function void clear_table();
      ticks = '0;
      cur_slot = 0;
      mismatches = 0;
      for (int i = 0; i < NSLOT; i++) begin
        valid_q[i]  = 1'b0;
        status_q[i] = TS_READY;
        reason_q[i] = WHY_NONE;
        object_q[i] = '0;
        wake_q[i]   = '0;
        prio_q[i]   = '0;
        slices_q[i] = '0;
      end
    endfunction

    function int unsigned eff_prio(int unsigned s);
      return valid_q[s] ? prio_q[s] : 0;
    endfunction

    function int unsigned eff_slices(int unsigned s);
      return valid_q[s] ? slices_q[s] : 0;
    endfunction

    function void park_running();
      if (status_q[cur_slot] == TS_RUNNING) status_q[cur_slot] = TS_READY;
    endfunction

    function void block_running(reason_e why, logic [OBJ_W-1:0] obj);
      status_q[cur_slot] = TS_BLOCKED;
      reason_q[cur_slot] = why;
      object_q[cur_slot] = obj;
    endfunction

    function logic release_waiter(reason_e why, logic [OBJ_W-1:0] obj);
      for (int i = 0; i < NTASK; i++) begin
        if (valid_q[i] && status_q[i] == TS_BLOCKED && reason_q[i] == why &&
            object_q[i] == obj) begin
          status_q[i] = TS_READY;
          return eff_prio(i) > eff_prio(cur_slot);
        end
      end
      return 1'b0;
    endfunction

    function logic run_tick();
      logic sw;
      int unsigned r;
      sw = 1'b0;
      r = cur_slot;
      ticks = ticks + 1;
      for (int i = 0; i < NTASK; i++) begin
        if (valid_q[i] && status_q[i] == TS_BLOCKED && reason_q[i] == WHY_TICK &&
            wake_q[i] <= ticks) begin
          status_q[i] = TS_READY;
          if (eff_prio(i) > eff_prio(r)) sw = 1'b1;
        end
      end
      // slice exhausted when the count has reached the priority
      if (eff_prio(r) == eff_slices(r)) begin
        if (status_q[r] == TS_RUNNING) status_q[r] = TS_READY;
        slices_q[r] = '0;
        sw = 1'b1;
      end else begin
        slices_q[r] = slices_q[r] + 1'b1;
      end
      return sw;
    endfunction

    function void round_robin();
      int unsigned pick, idx;
      pick = NTASK;
      for (int k = 1; k <= NTASK; k++) begin
        idx = (cur_slot + k) % NSLOT;
        if (idx != NTASK && idx != cur_slot && valid_q[idx] && status_q[idx] == TS_READY) begin
          pick = idx;
          break;
        end
      end
      park_running();
      if (pick != NTASK) status_q[NTASK] = TS_READY;
      cur_slot = pick;
      status_q[pick] = TS_RUNNING;
    endfunction

    function void start_first();
      int unsigned pick;
      pick = NTASK;
      for (int i = NTASK - 1; i >= 0; i--) if (valid_q[i]) pick = i;
      park_running();
      cur_slot = pick;
      status_q[pick] = TS_RUNNING;
    endfunction

    // Called for every accepted transaction.
    function void note_event(event_t ev);
      sched_res_t res;
      int unsigned s;
      res = '{1'b0, '0, '0, 1'b0};
      case (ev.op)
        OP_CREATE: begin
          if (ev.prio > NTASK) begin
            res.err = 1'b1;
          end else begin
            s = NTASK - ev.prio;
            valid_q[s] = 1'b1;
            status_q[s] = TS_READY;
            prio_q[s] = ev.prio;
            slices_q[s] = '0;
            res.created = TASK_W'(s);
          end
        end
        OP_START:       start_first();
        OP_BLOCK_MUTEX: begin block_running(WHY_MUTEX, ev.obj); res.sw_req = 1'b1; end
        OP_BLOCK_SEM:   begin block_running(WHY_SEM, ev.obj); res.sw_req = 1'b1; end
        OP_DELAY: begin
          block_running(WHY_TICK, '0);
          wake_q[cur_slot] = ticks + ev.dly;
          res.sw_req = 1'b1;
        end
        OP_UNBLOCK_MUTEX: if (ev.unlocked) res.sw_req = release_waiter(WHY_MUTEX, ev.obj);
        OP_UNBLOCK_SEM:   res.sw_req = release_waiter(WHY_SEM, ev.obj);
        OP_TICK:          res.sw_req = run_tick();
        OP_SWITCH:        round_robin();
        default: ;
      endcase
      res.run = TASK_W'(cur_slot);
      expected_q.push_back(res);
    endfunction

    function void check_result(sched_res_t act);
      sched_res_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sw=%0d run=%0d slot=%0d err=%0d",
                                       act.sw_req, act.run, act.created, act.err);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.sw_req !== exp_r.sw_req || act.run !== exp_r.run ||
          act.created !== exp_r.created || act.err !== exp_r.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp sw=%0d run=%0d slot=%0d err=%0d, ",
                    "got sw=%0d run=%0d slot=%0d err=%0d"},
                   exp_r.sw_req, exp_r.run, exp_r.created, exp_r.err,
                   act.sw_req, act.run, act.created, act.err);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [OP_W-1:0]   op_i = '0;
  logic [PRIO_W-1:0] priority_req_i = '0;
  logic [OBJ_W-1:0]  object_id_i = '0;
  logic              mutex_unlocked_i = 1'b0;
  logic [TICK_W-1:0] delay_ticks_i = '0;
  logic busy_o, done_o, switch_request_o, error_o;
  logic [TASK_W-1:0] running_task_o, created_slot_o;

  sched_scoreboard sb = new();
  int  quiet_cycles = 0;
  logic no_gaps = 1'b0;

  always #6 clk_i = ~clk_i;

  rtos_task_scheduler_core #(.MAX_TASKS(NTASK)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .priority_req_i, .object_id_i,
    .mutex_unlocked_i, .delay_ticks_i, .done_o, .switch_request_o, .running_task_o,
    .created_slot_o, .error_o
  );

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result('{switch_request_o, running_task_o, created_slot_o, error_o});
      if (done_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drive one transaction, starting and ending at a falling edge.
  task automatic send_event(event_t ev);
    while (!no_gaps && $urandom_range(0, 99) < 31) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = ev.op;
    priority_req_i = ev.prio;
    object_id_i = ev.obj;
    mutex_unlocked_i = ev.unlocked;
    delay_ticks_i = ev.dly;
    do @(posedge clk_i); while (busy_o);
    sb.note_event(ev);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [PRIO_W-1:0] prio,
                         logic [OBJ_W-1:0] obj, logic unl, logic [TICK_W-1:0] dly);
    event_t ev;
    ev = '{op, prio, obj, unl, dly};
    send_event(ev);
  endtask

  function automatic event_t random_event();
    event_t ev;
    int r;
    ev.prio = PRIO_W'($urandom);
    ev.obj = ($urandom_range(0, 9) < 8) ? OBJ_W'($urandom_range(0, 3)) : OBJ_W'($urandom);
    ev.unlocked = $urandom_range(0, 3) != 0;
    r = $urandom_range(0, 9);
    ev.dly = (r < 7) ? $urandom_range(0, 6) :
             (r < 9) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      ev.op = OP_CREATE;
      if ($urandom_range(0, 9) != 0) ev.prio = PRIO_W'($urandom_range(0, NTASK));
    end
    else if (r < 12) ev.op = OP_START;
    else if (r < 20) ev.op = OP_BLOCK_MUTEX;
    else if (r < 28) ev.op = OP_BLOCK_SEM;
    else if (r < 38) ev.op = OP_DELAY;
    else if (r < 48) ev.op = OP_UNBLOCK_MUTEX;
    else if (r < 56) ev.op = OP_UNBLOCK_SEM;
    else if (r < 85) ev.op = OP_TICK;
    else if (r < 96) ev.op = OP_SWITCH;
    else ev.op = OP_W'($urandom_range(9, 15));
    return ev;
  endfunction

  initial begin
    sb.clear_table();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // empty table: tick on a never-created slot, start with nothing, block and switch to idle
    send_op(OP_TICK, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_START, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_BLOCK_MUTEX, 4'd0, 8'hFF, 1'b1, 32'd0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 1'b0, 32'd0);
    // creates, the too-large priorities included
    send_op(OP_CREATE, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_CREATE, 4'd8, 8'd0, 1'b0, 32'd0);
    send_op(OP_CREATE, 4'd9, 8'd0, 1'b0, 32'd0);
    send_op(OP_CREATE, 4'd15, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_op(OP_CREATE, 4'd5, 8'd0, 1'b0, 32'd0);
    send_op(OP_START, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_START, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_TICK, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_DELAY, 4'd0, 8'd0, 1'b0, 32'hFFFF_FFFF);
    send_op(OP_SWITCH, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_BLOCK_MUTEX, 4'd0, 8'hFF, 1'b0, 32'd0);
    send_op(OP_TICK, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_UNBLOCK_MUTEX, 4'd0, 8'hFF, 1'b0, 32'd0);
    send_op(OP_UNBLOCK_MUTEX, 4'd0, 8'hFF, 1'b1, 32'd0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_BLOCK_SEM, 4'd0, 8'd7, 1'b0, 32'd0);
    send_op(OP_DELAY, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(OP_UNBLOCK_SEM, 4'd0, 8'd7, 1'b0, 32'd0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(4'd9, 4'd0, 8'd0, 1'b0, 32'd0);
    send_op(4'd15, 4'd0, 8'd0, 1'b0, 32'd0);
    // random traffic, with a stretch of back-to-back commands
    for (int n = 0; n < 500; n++) begin
      no_gaps = (n >= 200 && n < 300);
      send_event(random_event());
    end
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
